>>> sv/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sm83ld check failed: same-cycle implication");

// next-cycle implication, disabled while reset is low
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sm83ld check failed: next-cycle implication");

`endif

>>> sv/sm83ld_pkg.sv
// types and constants of the sm83 load instruction unit
`timescale 1ns / 1ps
`default_nettype none

package sm83ld_pkg;

  localparam int MEM_ADDR_BITS = 16;
  localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;

  // register file after reset
  localparam logic [7:0] RST_A = 8'h01;
  localparam logic [7:0] RST_F = 8'hB0;
  localparam logic [7:0] RST_B = 8'h00;
  localparam logic [7:0] RST_C = 8'h13;
  localparam logic [7:0] RST_D = 8'h00;
  localparam logic [7:0] RST_E = 8'hD8;
  localparam logic [7:0] RST_H = 8'h01;
  localparam logic [7:0] RST_L = 8'h4D;
  localparam logic [15:0] RST_SP = 16'hFFFE;
  localparam logic [15:0] RST_PC = 16'h0100;

  localparam logic [7:0] HIGH_PAGE = 8'hFF;

  // operand slots
  localparam logic [2:0] SLOT_B   = 3'd0;
  localparam logic [2:0] SLOT_C   = 3'd1;
  localparam logic [2:0] SLOT_D   = 3'd2;
  localparam logic [2:0] SLOT_E   = 3'd3;
  localparam logic [2:0] SLOT_H   = 3'd4;
  localparam logic [2:0] SLOT_L   = 3'd5;
  localparam logic [2:0] SLOT_MEM = 3'd6;
  localparam logic [2:0] SLOT_A   = 3'd7;

  // opcodes
  localparam logic [7:0] OP_LD_BC_NN  = 8'h01;
  localparam logic [7:0] OP_LD_DE_NN  = 8'h11;
  localparam logic [7:0] OP_LD_HL_NN  = 8'h21;
  localparam logic [7:0] OP_LD_SP_NN  = 8'h31;
  localparam logic [7:0] OP_LD_BCI_A  = 8'h02;
  localparam logic [7:0] OP_LD_DEI_A  = 8'h12;
  localparam logic [7:0] OP_LD_A_BCI  = 8'h0A;
  localparam logic [7:0] OP_LD_A_DEI  = 8'h1A;
  localparam logic [7:0] OP_LDI_HL_A  = 8'h22;
  localparam logic [7:0] OP_LDD_HL_A  = 8'h32;
  localparam logic [7:0] OP_LDI_A_HL  = 8'h2A;
  localparam logic [7:0] OP_LDD_A_HL  = 8'h3A;
  localparam logic [7:0] OP_LD_NN_SP  = 8'h08;
  localparam logic [7:0] OP_LDH_N_A   = 8'hE0;
  localparam logic [7:0] OP_LDH_A_N   = 8'hF0;
  localparam logic [7:0] OP_LDH_C_A   = 8'hE2;
  localparam logic [7:0] OP_LDH_A_C   = 8'hF2;
  localparam logic [7:0] OP_LD_NNI_A  = 8'hEA;
  localparam logic [7:0] OP_LD_A_NNI  = 8'hFA;
  localparam logic [7:0] OP_LD_HL_SPE = 8'hF8;
  localparam logic [7:0] OP_LD_SP_HL  = 8'hF9;
  localparam logic [7:0] OP_HALT      = 8'h76;
  localparam logic [7:0] OP_NOP       = 8'h00;
  localparam logic [7:0] OP_LD_C_N    = 8'h0E;
  localparam logic [7:0] OP_LD_HLI_N  = 8'h36;
  localparam logic [7:0] OP_PREFIX_CB = 8'hCB;
  localparam logic [7:0] OP_RST_38    = 8'hFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_HIGH
  } ex_state_t;

  // first member is the top byte: slot i sits in bits 8i+7:8i
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] f;
    logic [7:0] l;
    logic [7:0] h;
    logic [7:0] e;
    logic [7:0] d;
    logic [7:0] c;
    logic [7:0] b;
  } regs_t;

  typedef struct packed {
    logic                     en;
    logic [MEM_ADDR_BITS-1:0] addr;
    logic [7:0]               data;
  } mem_wr_t;

  typedef struct packed {
    logic        last;
    logic        bus_write;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
    logic [15:0] af_value;
    logic [15:0] bc_value;
    logic [15:0] de_value;
    logic [15:0] hl_value;
    logic [15:0] sp_value;
    logic [15:0] pc_value;
    logic [4:0]  cycle_cost;
  } res_t;

endpackage

`default_nettype wire

>>> sv/sm83ld_dmem.sv
// data memory with a clearing sweep after reset
`timescale 1ns / 1ps
`default_nettype none

module sm83ld_dmem (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                rd_en,
  input  wire logic [sm83ld_pkg::MEM_ADDR_BITS-1:0] rd_addr,
  output logic      [7:0]                          rd_data,
  input  wire sm83ld_pkg::mem_wr_t                 wr,
  output logic                                     clr_busy
);
  import sm83ld_pkg::*;

  logic [7:0]             mem [MEM_DEPTH];
  logic [MEM_ADDR_BITS:0] clr_cnt_r;
  logic [7:0]             rd_data_r;

  assign clr_busy = !clr_cnt_r[MEM_ADDR_BITS];
  assign rd_data  = rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clr_busy) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_cnt_r[MEM_ADDR_BITS-1:0]] <= 8'h00;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> sv/sm83_load_instruction_unit.sv
// top level of the sm83 load instruction unit
//
//  channel  ports            direction  contents
//  input    in_t*            in         one instruction per word
//  result   out_t*           out        one or two words per instruction
//
// an instruction is accepted with its memory read, then executed and written back
// ld (nn),sp writes its low byte and then its high byte, both through the single memory write port
// after reset the data memory is cleared one byte per cycle, all 65536 bytes, with in_tready low
// results queue in a two-word buffer, execution waits while it is full
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sm83_load_instruction_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [23:0]   in_tdata,   // opcode, imm_low, imm_high
  input  wire logic          in_tuser,   // cb_prefixed
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic      [127:0]  out_tdata,  // bus_address, bus_data, af_value, bc_value,
                                         // de_value, hl_value, sp_value, pc_value,
                                         // cycle_cost, zero fill
  output logic               out_tuser,  // bus_write
  output logic               out_tlast
);
  import sm83ld_pkg::*;

  ex_state_t   state_r, state_nxt;
  regs_t       rf_r, rf_nxt;
  logic [15:0] sp_r, sp_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [7:0]  ex_op_r, ex_lo_r, ex_hi_r;
  logic        ex_cb_r;

  res_t        fifo_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        fifo_full, push, pop;
  res_t        push_res;

  logic        in_acc, commit, clr_busy;
  logic [15:0] rd_addr16, wa16;
  logic [7:0]  rd_data;
  mem_wr_t     mem_wr;

  function automatic logic [7:0] get_r8(input regs_t r, input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      SLOT_B:  v = r.b;
      SLOT_C:  v = r.c;
      SLOT_D:  v = r.d;
      SLOT_E:  v = r.e;
      SLOT_H:  v = r.h;
      SLOT_L:  v = r.l;
      SLOT_A:  v = r.a;
      default: v = r.f;
    endcase
    return v;
  endfunction

  function automatic regs_t set_r8(input regs_t r, input logic [2:0] idx,
                                   input logic [7:0] v);
    regs_t o;
    o = r;
    case (idx)
      SLOT_B:  o.b = v;
      SLOT_C:  o.c = v;
      SLOT_D:  o.d = v;
      SLOT_E:  o.e = v;
      SLOT_H:  o.h = v;
      SLOT_L:  o.l = v;
      SLOT_A:  o.a = v;
      default: o.f = v;
    endcase
    return o;
  endfunction

  // read address from the incoming word and the current register state
  always_comb begin
    logic [7:0] op;
    op = in_tdata[7:0];
    rd_addr16 = {rf_r.h, rf_r.l};
    case (op)
      OP_LD_A_BCI: rd_addr16 = {rf_r.b, rf_r.c};
      OP_LD_A_DEI: rd_addr16 = {rf_r.d, rf_r.e};
      OP_LDH_A_N:  rd_addr16 = {HIGH_PAGE, in_tdata[15:8]};
      OP_LDH_A_C:  rd_addr16 = {HIGH_PAGE, rf_r.c};
      OP_LD_A_NNI: rd_addr16 = in_tdata[23:8];
      default:     rd_addr16 = {rf_r.h, rf_r.l};
    endcase
  end

  assign in_tready = (state_r == ST_IDLE) && !clr_busy;
  assign in_acc    = in_tvalid && in_tready;

  sm83ld_dmem u_dmem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr  (rd_addr16[MEM_ADDR_BITS-1:0]),
    .rd_data  (rd_data),
    .wr       (mem_wr),
    .clr_busy (clr_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rf_r    <= '{a: RST_A, f: RST_F, l: RST_L, h: RST_H,
                   e: RST_E, d: RST_D, c: RST_C, b: RST_B};
      sp_r    <= RST_SP;
      pc_r    <= RST_PC;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        rf_r <= rf_nxt;
        sp_r <= sp_nxt;
        pc_r <= pc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ex_op_r <= in_tdata[7:0];
      ex_lo_r <= in_tdata[15:8];
      ex_hi_r <= in_tdata[23:16];
      ex_cb_r <= in_tuser;
    end
  end

  always_comb begin
    logic [15:0] nn, nn1, hl, sum;
    logic [2:0]  dst, src;
    logic [1:0]  len;
    logic [4:0]  cost;
    logic        we, hf, cf, two_wr;
    logic [7:0]  wd;

    nn     = {ex_hi_r, ex_lo_r};
    nn1    = nn + 16'd1;
    hl     = {rf_r.h, rf_r.l};
    dst    = ex_op_r[5:3];
    src    = ex_op_r[2:0];
    sum    = sp_r + {{8{ex_lo_r[7]}}, ex_lo_r};
    hf     = ({1'b0, sp_r[3:0]} + {1'b0, ex_lo_r[3:0]}) > 5'h0F;
    cf     = ({1'b0, sp_r[7:0]} + {1'b0, ex_lo_r}) > 9'h0FF;
    len    = 2'd1;
    cost   = 5'd0;
    we     = 1'b0;
    wa16   = 16'h0000;
    wd     = 8'h00;
    two_wr = 1'b0;
    rf_nxt = rf_r;
    sp_nxt = sp_r;

    if (ex_cb_r) begin
      len = 2'd2;
    end else if (ex_op_r[7:6] == 2'b01 && ex_op_r != OP_HALT) begin
      if (src == SLOT_MEM) begin
        rf_nxt = set_r8(rf_r, dst, rd_data);
        cost   = 5'd8;
      end else if (dst == SLOT_MEM) begin
        we   = 1'b1;
        wa16 = hl;
        wd   = get_r8(rf_r, src);
        cost = 5'd8;
      end else begin
        rf_nxt = set_r8(rf_r, dst, get_r8(rf_r, src));
        cost   = 5'd4;
      end
    end else if (ex_op_r[7:6] == 2'b00 && src == SLOT_MEM) begin
      len = 2'd2;
      if (dst == SLOT_MEM) begin
        we   = 1'b1;
        wa16 = hl;
        wd   = ex_lo_r;
        cost = 5'd12;
      end else begin
        rf_nxt = set_r8(rf_r, dst, ex_lo_r);
        cost   = 5'd8;
      end
    end else begin
      case (ex_op_r)
        OP_LD_BC_NN: begin
          rf_nxt.b = ex_hi_r; rf_nxt.c = ex_lo_r; len = 2'd3; cost = 5'd12;
        end
        OP_LD_DE_NN: begin
          rf_nxt.d = ex_hi_r; rf_nxt.e = ex_lo_r; len = 2'd3; cost = 5'd12;
        end
        OP_LD_HL_NN: begin
          rf_nxt.h = ex_hi_r; rf_nxt.l = ex_lo_r; len = 2'd3; cost = 5'd12;
        end
        OP_LD_SP_NN: begin
          sp_nxt = nn; len = 2'd3; cost = 5'd12;
        end
        OP_LD_BCI_A: begin
          we = 1'b1; wa16 = {rf_r.b, rf_r.c}; wd = rf_r.a; cost = 5'd8;
        end
        OP_LD_DEI_A: begin
          we = 1'b1; wa16 = {rf_r.d, rf_r.e}; wd = rf_r.a; cost = 5'd8;
        end
        OP_LD_A_BCI, OP_LD_A_DEI, OP_LDH_A_C: begin
          rf_nxt.a = rd_data; cost = 5'd8;
        end
        OP_LDI_HL_A, OP_LDD_HL_A: begin
          we   = 1'b1;
          wa16 = hl;
          wd   = rf_r.a;
          {rf_nxt.h, rf_nxt.l} = (ex_op_r == OP_LDI_HL_A) ? hl + 16'd1 : hl - 16'd1;
          cost = 5'd8;
        end
        OP_LDI_A_HL, OP_LDD_A_HL: begin
          rf_nxt.a = rd_data;
          {rf_nxt.h, rf_nxt.l} = (ex_op_r == OP_LDI_A_HL) ? hl + 16'd1 : hl - 16'd1;
          cost = 5'd8;
        end
        OP_LD_NN_SP: begin
          we = 1'b1; wa16 = nn; wd = sp_r[7:0]; two_wr = 1'b1;
          len = 2'd3; cost = 5'd20;
        end
        OP_LDH_N_A: begin
          we = 1'b1; wa16 = {HIGH_PAGE, ex_lo_r}; wd = rf_r.a; len = 2'd2; cost = 5'd12;
        end
        OP_LDH_A_N: begin
          rf_nxt.a = rd_data; len = 2'd2; cost = 5'd12;
        end
        OP_LDH_C_A: begin
          we = 1'b1; wa16 = {HIGH_PAGE, rf_r.c}; wd = rf_r.a; cost = 5'd8;
        end
        OP_LD_NNI_A: begin
          we = 1'b1; wa16 = nn; wd = rf_r.a; len = 2'd3; cost = 5'd16;
        end
        OP_LD_A_NNI: begin
          rf_nxt.a = rd_data; len = 2'd3; cost = 5'd16;
        end
        OP_LD_HL_SPE: begin
          {rf_nxt.h, rf_nxt.l} = sum;
          rf_nxt.f = {2'b00, hf, cf, 4'h0};
          len = 2'd2; cost = 5'd12;
        end
        OP_LD_SP_HL: begin
          sp_nxt = hl; cost = 5'd8;
        end
        default: begin
          len = 2'd1;
        end
      endcase
    end
    rf_nxt.f = {rf_nxt.f[7:4], 4'h0};
    pc_nxt   = pc_r + {14'd0, len};

    state_nxt = state_r;
    commit    = 1'b0;
    push      = 1'b0;
    push_res  = '0;
    mem_wr    = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!fifo_full) begin
          commit      = 1'b1;
          push        = 1'b1;
          mem_wr.en   = we;
          mem_wr.addr = wa16[MEM_ADDR_BITS-1:0];
          mem_wr.data = wd;
          push_res    = '{last: !two_wr, bus_write: we, bus_address: wa16,
                          bus_data: wd, af_value: {rf_nxt.a, rf_nxt.f},
                          bc_value: {rf_nxt.b, rf_nxt.c},
                          de_value: {rf_nxt.d, rf_nxt.e},
                          hl_value: {rf_nxt.h, rf_nxt.l},
                          sp_value: sp_nxt, pc_value: pc_nxt, cycle_cost: cost};
          state_nxt   = two_wr ? ST_HIGH : ST_IDLE;
        end
      end
      ST_HIGH: begin
        if (!fifo_full) begin
          push        = 1'b1;
          mem_wr.en   = 1'b1;
          mem_wr.addr = nn1[MEM_ADDR_BITS-1:0];
          mem_wr.data = sp_r[15:8];
          push_res    = '{last: 1'b1, bus_write: 1'b1, bus_address: nn1,
                          bus_data: sp_r[15:8], af_value: {rf_r.a, rf_r.f},
                          bc_value: {rf_r.b, rf_r.c},
                          de_value: {rf_r.d, rf_r.e},
                          hl_value: {rf_r.h, rf_r.l},
                          sp_value: sp_r, pc_value: pc_r, cycle_cost: 5'd20};
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // two-word result buffer
  assign fifo_full  = (cnt_r == 2'd2);
  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= push_res;
    end
  end

  res_t head;
  assign head      = fifo_r[rd_ptr_r];
  assign out_tlast = head.last;
  assign out_tuser = head.bus_write;
  assign out_tdata = {3'b000, head.cycle_cost, head.pc_value, head.sp_value,
                      head.hl_value, head.de_value, head.bc_value, head.af_value,
                      head.bus_data, head.bus_address};

  `CHK_IMPLY(a_fifo_bound, clk, rst_n, 1'b1, cnt_r != 2'd3)
  `CHK_NEXT(a_accept_exec, clk, rst_n, in_acc, state_r == ST_EXEC)
  `CHK_IMPLY(a_no_wr_clear, clk, rst_n, mem_wr.en, !clr_busy)
  `CHK_IMPLY(a_high_only_sp, clk, rst_n, state_r == ST_HIGH, ex_op_r == OP_LD_NN_SP && !ex_cb_r)

endmodule

`default_nettype wire

>>> verif/testbench.sv
// self-checking testbench for the sm83 load instruction unit
`timescale 1ns / 1ps

module testbench;
  import sm83ld_pkg::*;

  class ld_scoreboard;
    logic [7:0]  regs [0:7];
    logic [15:0] sp;
    logic [15:0] pc;
    logic [7:0]  mem [0:MEM_DEPTH-1];
    res_t        pending [$];
    logic [15:0] wr_addr [0:1];
    logic [7:0]  wr_data [0:1];
    int          wr_n;
    int          errors;
    int          checked;
    int          writes_seen;

    function new();
      regs[SLOT_A]   = RST_A;
      regs[SLOT_MEM] = RST_F;
      regs[SLOT_B]   = RST_B;
      regs[SLOT_C]   = RST_C;
      regs[SLOT_D]   = RST_D;
      regs[SLOT_E]   = RST_E;
      regs[SLOT_H]   = RST_H;
      regs[SLOT_L]   = RST_L;
      sp = RST_SP;
      pc = RST_PC;
      foreach (mem[i]) mem[i] = 8'h00;
      errors = 0;
      checked = 0;
      writes_seen = 0;
    endfunction

    function logic [15:0] pair(input logic [2:0] hi_slot);
      return {regs[hi_slot], regs[hi_slot + 3'd1]};
    endfunction

    function void set_pair(input logic [2:0] hi_slot, input logic [15:0] v);
      regs[hi_slot]        = v[15:8];
      regs[hi_slot + 3'd1] = v[7:0];
    endfunction

    function logic [7:0] fetch(input logic [15:0] addr);
      return mem[addr & (MEM_DEPTH - 1)];
    endfunction

    function void store(input logic [15:0] addr, input logic [7:0] v);
      mem[addr & (MEM_DEPTH - 1)] = v;
      if (wr_n < 2) begin
        wr_addr[wr_n] = addr;
        wr_data[wr_n] = v;
        wr_n++;
      end
    endfunction

    // predict the words of one accepted instruction
    function void note_instr(input logic [7:0] op, input logic cb,
                             input logic [7:0] lo, input logic [7:0] hi);
      logic [15:0] nn;
      logic [15:0] hl;
      logic [15:0] ext;
      logic [2:0]  d;
      logic [2:0]  s;
      logic [4:0]  nib;
      logic [8:0]  sum;
      int          len;
      int          cost;
      int          nres;
      res_t        w;
      nn = {hi, lo};
      hl = pair(SLOT_H);
      len = 1;
      cost = 0;
      wr_n = 0;
      if (cb) begin
        len = 2;
      end else if (op >= 8'h40 && op <= 8'h7F && op != OP_HALT) begin
        d = op[5:3];
        s = op[2:0];
        if (s == SLOT_MEM) begin
          regs[d] = fetch(hl);
          cost = 8;
        end else if (d == SLOT_MEM) begin
          store(hl, regs[s]);
          cost = 8;
        end else begin
          regs[d] = regs[s];
          cost = 4;
        end
      end else if (op < 8'h40 && (op & 8'hC7) == 8'h06) begin
        d = op[5:3];
        len = 2;
        if (d == SLOT_MEM) begin
          store(hl, lo);
          cost = 12;
        end else begin
          regs[d] = lo;
          cost = 8;
        end
      end else begin
        case (op)
          OP_LD_BC_NN: begin set_pair(SLOT_B, nn); len = 3; cost = 12; end
          OP_LD_DE_NN: begin set_pair(SLOT_D, nn); len = 3; cost = 12; end
          OP_LD_HL_NN: begin set_pair(SLOT_H, nn); len = 3; cost = 12; end
          OP_LD_SP_NN: begin sp = nn; len = 3; cost = 12; end
          OP_LD_BCI_A: begin store(pair(SLOT_B), regs[SLOT_A]); cost = 8; end
          OP_LD_DEI_A: begin store(pair(SLOT_D), regs[SLOT_A]); cost = 8; end
          OP_LD_A_BCI: begin regs[SLOT_A] = fetch(pair(SLOT_B)); cost = 8; end
          OP_LD_A_DEI: begin regs[SLOT_A] = fetch(pair(SLOT_D)); cost = 8; end
          OP_LDI_HL_A: begin
            store(hl, regs[SLOT_A]);
            set_pair(SLOT_H, hl + 16'd1);
            cost = 8;
          end
          OP_LDD_HL_A: begin
            store(hl, regs[SLOT_A]);
            set_pair(SLOT_H, hl - 16'd1);
            cost = 8;
          end
          OP_LDI_A_HL: begin
            regs[SLOT_A] = fetch(hl);
            set_pair(SLOT_H, hl + 16'd1);
            cost = 8;
          end
          OP_LDD_A_HL: begin
            regs[SLOT_A] = fetch(hl);
            set_pair(SLOT_H, hl - 16'd1);
            cost = 8;
          end
          OP_LD_NN_SP: begin
            store(nn, sp[7:0]);
            store(nn + 16'd1, sp[15:8]);
            len = 3;
            cost = 20;
          end
          OP_LDH_N_A: begin store({HIGH_PAGE, lo}, regs[SLOT_A]); len = 2; cost = 12; end
          OP_LDH_A_N: begin regs[SLOT_A] = fetch({HIGH_PAGE, lo}); len = 2; cost = 12; end
          OP_LDH_C_A: begin store({HIGH_PAGE, regs[SLOT_C]}, regs[SLOT_A]); cost = 8; end
          OP_LDH_A_C: begin regs[SLOT_A] = fetch({HIGH_PAGE, regs[SLOT_C]}); cost = 8; end
          OP_LD_NNI_A: begin store(nn, regs[SLOT_A]); len = 3; cost = 16; end
          OP_LD_A_NNI: begin regs[SLOT_A] = fetch(nn); len = 3; cost = 16; end
          OP_LD_HL_SPE: begin
            ext = {{8{lo[7]}}, lo};
            nib = {1'b0, sp[3:0]} + {1'b0, lo[3:0]};
            sum = {1'b0, sp[7:0]} + {1'b0, lo};
            set_pair(SLOT_H, sp + ext);
            regs[SLOT_MEM] = {2'b00, nib[4], sum[8], 4'h0};
            len = 2;
            cost = 12;
          end
          OP_LD_SP_HL: begin sp = hl; cost = 8; end
          default: ;
        endcase
      end
      regs[SLOT_MEM] = regs[SLOT_MEM] & 8'hF0;
      pc = pc + 16'(len);
      nres = (wr_n != 0) ? wr_n : 1;
      for (int k = 0; k < nres; k++) begin
        w.bus_write   = (k < wr_n);
        w.bus_address = (k < wr_n) ? wr_addr[k] : 16'h0000;
        w.bus_data    = (k < wr_n) ? wr_data[k] : 8'h00;
        w.af_value    = {regs[SLOT_A], regs[SLOT_MEM]};
        w.bc_value    = pair(SLOT_B);
        w.de_value    = pair(SLOT_D);
        w.hl_value    = pair(SLOT_H);
        w.sp_value    = sp;
        w.pc_value    = pc;
        w.cycle_cost  = 5'(cost);
        w.last        = (k + 1 == nres);
        pending.push_back(w);
      end
    endfunction

    function void diff(input string field, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, field, want, got);
      end
    endfunction

    function void check_word(input res_t got);
      res_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result word expected none actual %h", $time, got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.bus_write) writes_seen++;
      diff("bus_write", want.bus_write, got.bus_write);
      diff("bus_address", want.bus_address, got.bus_address);
      diff("bus_data", want.bus_data, got.bus_data);
      diff("af_value", want.af_value, got.af_value);
      diff("bc_value", want.bc_value, got.bc_value);
      diff("de_value", want.de_value, got.de_value);
      diff("hl_value", want.hl_value, got.hl_value);
      diff("sp_value", want.sp_value, got.sp_value);
      diff("pc_value", want.pc_value, got.pc_value);
      diff("cycle_cost", want.cycle_cost, got.cycle_cost);
      diff("last", want.last, got.last);
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [23:0]  in_tdata = 24'h000000;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;

  logic         calm = 1'b0;
  int           sent = 0;
  int           cb_sent = 0;
  logic [7:0]   load_ops [$];
  ld_scoreboard sb;

  sm83_load_instruction_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // alternate between stretches with idling and stretches without
  initial begin
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk);
      calm <= ~calm;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_page();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'hFF;
    if (r < 60) return 8'hC0;
    if (r < 70) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_word(input logic [7:0] op, input logic cb,
                           input logic [7:0] lo, input logic [7:0] hi);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {hi, lo, op};
    in_tuser  <= cb;
    do @(posedge clk); while (!in_tready);
    sb.note_instr(op, cb, lo, hi);
    sent++;
    if (cb) cb_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic random_item();
    int         r;
    logic [7:0] lo;
    logic [7:0] hi;
    r = $urandom_range(0, 99);
    lo = 8'($urandom_range(0, 255));
    hi = pick_page();
    if (r < 60) begin
      send_word(load_ops[$urandom_range(0, load_ops.size() - 1)], 1'b0, lo, hi);
    end else if (r < 72) begin
      send_word(8'($urandom_range(0, 255)), 1'b1, lo, hi);
    end else if (r < 82) begin
      send_word(8'($urandom_range(0, 255)), 1'b0, lo, hi);
    end else if (r < 89) begin
      // set hl, store through it, run a random load, then load a through hl
      send_word(OP_LD_HL_NN, 1'b0, lo, hi);
      case ($urandom_range(0, 2))
        0: send_word(OP_LD_HLI_N, 1'b0, 8'($urandom_range(0, 255)), 8'h00);
        1: send_word(OP_LDI_HL_A, 1'b0, 8'h00, 8'h00);
        default: send_word(OP_LDD_HL_A, 1'b0, 8'h00, 8'h00);
      endcase
      send_word(load_ops[$urandom_range(0, load_ops.size() - 1)], 1'b0, lo, hi);
      send_word($urandom_range(0, 1) ? OP_LDI_A_HL : OP_LDD_A_HL, 1'b0, 8'h00, 8'h00);
    end else if (r < 95) begin
      // save sp, load a from its address or the next one in the same page, then move sp through hl
      send_word(OP_LD_NN_SP, 1'b0, lo, hi);
      send_word(OP_LD_A_NNI, 1'b0, lo + 8'($urandom_range(0, 1)), hi);
      send_word(OP_LD_HL_SPE, 1'b0, 8'($urandom_range(0, 255)), 8'h00);
      send_word(OP_LD_SP_HL, 1'b0, 8'h00, 8'h00);
    end else begin
      // high page through n and through c
      send_word(OP_LDH_N_A, 1'b0, lo, hi);
      send_word(OP_LD_C_N, 1'b0, lo, hi);
      send_word(OP_LDH_A_C, 1'b0, lo, hi);
      send_word(OP_LDH_C_A, 1'b0, lo, hi);
      send_word(OP_LDH_A_N, 1'b0, lo, hi);
    end
  endtask

  // result side
  initial begin
    int   hold;
    res_t got;
    hold = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got.bus_address = out_tdata[15:0];
        got.bus_data    = out_tdata[23:16];
        got.af_value    = out_tdata[39:24];
        got.bc_value    = out_tdata[55:40];
        got.de_value    = out_tdata[71:56];
        got.hl_value    = out_tdata[87:72];
        got.sp_value    = out_tdata[103:88];
        got.pc_value    = out_tdata[119:104];
        got.cycle_cost  = out_tdata[124:120];
        got.bus_write   = out_tuser;
        got.last        = out_tlast;
        sb.check_word(got);
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        hold = pick_gap();
        out_tready <= (hold == 0);
      end
    end
  end

  initial begin
    bit drained_mid;
    sb = new();
    drained_mid = 0;
    for (int op = 8'h40; op <= 8'h7F; op++) if (op != OP_HALT) load_ops.push_back(8'(op));
    for (int op = 0; op < 8'h40; op++) if ((op & 8'hC7) == 8'h06) load_ops.push_back(8'(op));
    load_ops.push_back(OP_LD_BC_NN);  load_ops.push_back(OP_LD_DE_NN);
    load_ops.push_back(OP_LD_HL_NN);  load_ops.push_back(OP_LD_SP_NN);
    load_ops.push_back(OP_LD_BCI_A);  load_ops.push_back(OP_LD_DEI_A);
    load_ops.push_back(OP_LD_A_BCI);  load_ops.push_back(OP_LD_A_DEI);
    load_ops.push_back(OP_LDI_HL_A);  load_ops.push_back(OP_LDD_HL_A);
    load_ops.push_back(OP_LDI_A_HL);  load_ops.push_back(OP_LDD_A_HL);
    load_ops.push_back(OP_LD_NN_SP);  load_ops.push_back(OP_LDH_N_A);
    load_ops.push_back(OP_LDH_A_N);   load_ops.push_back(OP_LDH_C_A);
    load_ops.push_back(OP_LDH_A_C);   load_ops.push_back(OP_LD_NNI_A);
    load_ops.push_back(OP_LD_A_NNI);  load_ops.push_back(OP_LD_HL_SPE);
    load_ops.push_back(OP_LD_SP_HL);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    send_word(OP_NOP, 1'b0, 8'hFF, 8'hFF);
    send_word(OP_PREFIX_CB, 1'b0, 8'h00, 8'h00);
    send_word(OP_RST_38, 1'b1, 8'hFF, 8'hFF);
    send_word(OP_HALT, 1'b0, 8'h00, 8'h00);
    for (int op = 8'h41; op <= 8'h45; op++) send_word(8'(op), 1'b0, 8'h00, 8'h00);
    send_word(OP_LD_HLI_N, 1'b0, 8'hA5, 8'h00);
    send_word(OP_LD_NN_SP, 1'b0, 8'hFF, 8'hFF);
    send_word(OP_LD_A_NNI, 1'b0, 8'h00, 8'h00);
    send_word(OP_LD_SP_NN, 1'b0, 8'hFF, 8'h00);
    send_word(OP_LD_HL_SPE, 1'b0, 8'h01, 8'h00);
    send_word(OP_LD_HL_SPE, 1'b0, 8'h80, 8'h00);
    send_word(OP_LD_HL_SPE, 1'b0, 8'h7F, 8'h00);
    send_word(OP_LD_HL_NN, 1'b0, 8'hFF, 8'hFF);
    send_word(OP_LDI_HL_A, 1'b0, 8'h00, 8'h00);
    send_word(OP_LDD_A_HL, 1'b0, 8'h00, 8'h00);
    send_word(OP_LDH_N_A, 1'b0, 8'hFF, 8'h00);
    send_word(OP_LD_C_N, 1'b0, 8'hFF, 8'h00);
    send_word(OP_LDH_A_C, 1'b0, 8'h00, 8'h00);
    send_word(OP_LD_NNI_A, 1'b0, 8'h00, 8'h80);
    send_word(OP_LD_BCI_A, 1'b0, 8'h00, 8'h00);
    send_word(OP_LD_A_DEI, 1'b0, 8'h00, 8'h00);
    send_word(OP_LD_SP_HL, 1'b0, 8'h00, 8'h00);
    wait_drained();

    // random
    while (sent < 1100) begin
      random_item();
      if (!drained_mid && sent >= 550) begin
        drained_mid = 1;
        wait_drained();
      end
    end
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("sent %0d instructions (%0d with the cb prefix) across the load group",
             sent, cb_sent);
    $display("checked %0d result words, %0d of them memory writes", sb.checked,
             sb.writes_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
